>>> hdl/alm_pkg.sv
// Shared sizes, codes and sequencer states of the linked list manager.
package alm_pkg;

  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TALLY_W = $clog2(2 * DEPTH + 2);
  localparam int VALUE_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DROP   = 2'd1;
  localparam logic [1:0] OP_VERIFY = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_ARG = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_UNUSED  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_FREE,
    S_INS_PAR,
    S_INS_LINK,
    S_INS_TAIL,
    S_DRP_UNLINK,
    S_DRP_PUSH,
    S_DRP_FREE,
    S_VER_LIVE,
    S_VER_FREE,
    S_VER_STEP,
    S_VER_END,
    S_OUT
  } state_t;

endpackage

>>> hdl/array_linked_list_manager.sv
// Doubly linked list over a fixed node store with a free list, run by a small sequencer.
//
//  channel | dir | tdata / tuser                                   | width
//  s_      | in  | tuser: opcode                                   | 2
//          |     | tdata: parent_index, item_value, drop_index     | 48
//  m_      | out | tdata: new_index, status, backward_corrupt,     | 16
//          |     |        count_corrupt                            |
//
// One request at a time; the node memories have one write and one registered read a cycle.
// Verify walks the live list and then the free list node by node and cuts off a walk
// after DEPTH nodes. Reset clears the root link and the free list head and sets the
// slot count to one; node memories keep their contents. A stalled result is held in
// the output register while the next request is already being worked on; the
// sequencer waits only to hand over its own result.
module array_linked_list_manager
  import alm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // parent_index[6:0], item_value[38:7], drop_index[45:39], 0
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // new_index[6:0], status[8:7], backward_corrupt[9],
                                 // count_corrupt[10], 0
);

  state_t state, state_next;

  logic [IDX_W-1:0]   next_mem [DEPTH];
  logic [IDX_W-1:0]   prev_mem [DEPTH];
  logic [VALUE_W-1:0] val_mem  [DEPTH];

  logic [IDX_W-1:0]   root_next;
  logic [IDX_W-1:0]   next_rd, prev_rd;
  logic [IDX_W-1:0]   rd_addr;

  logic               next_we, prev_we, val_we;
  logic [IDX_W-1:0]   next_wa, next_wd, prev_wa, prev_wd;

  logic [IDX_W-1:0]   free_head;
  logic [CNT_W-1:0]   used_count;
  logic [IDX_W-1:0]   parent, node, nlink, cur, back;
  logic [VALUE_W-1:0] value;
  logic [CNT_W-1:0]   steps;
  logic [TALLY_W-1:0] tally;
  logic               walk_free, back_bad, over;
  logic [IDX_W-1:0]   res_index;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   out_index;
  logic [1:0]         out_status;
  logic               out_back, out_count;

  logic               accept, out_free;
  logic [1:0]         in_op;
  logic [IDX_W-1:0]   in_parent, in_drop;
  logic [VALUE_W-1:0] in_value;
  logic [IDX_W-1:0]   par_next;

  assign in_op     = s_tuser;
  assign in_parent = s_tdata[6:0];
  assign in_value  = s_tdata[38:7];
  assign in_drop   = s_tdata[45:39];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign m_tdata = {5'd0, out_count, out_back, out_status, out_index};

  // next link of the parent as it stands once the new node was cleared
  always_comb begin
    if (parent == node) begin
      par_next = '0;
    end else if (parent == '0) begin
      par_next = root_next;
    end else begin
      par_next = next_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = cur;
    next_we    = 1'b0;
    next_wa    = node;
    next_wd    = '0;
    prev_we    = 1'b0;
    prev_wa    = node;
    prev_wd    = '0;
    val_we     = 1'b0;
    case (state)
      S_IDLE: begin
        rd_addr = (in_op == OP_DROP) ? in_drop : free_head;
        if (accept) begin
          case (in_op)
            OP_INSERT: begin
              if (free_head != '0) begin
                state_next = S_INS_FREE;
              end else if (used_count >= DEPTH_CNT) begin
                state_next = S_OUT;
              end else begin
                state_next = S_INS_PAR;
              end
            end
            OP_DROP:   state_next = (in_drop == '0) ? S_OUT : S_DRP_UNLINK;
            OP_VERIFY: state_next = S_VER_LIVE;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_INS_FREE: begin
        // new free head loses its back link
        prev_we    = (next_rd != '0);
        prev_wa    = next_rd;
        prev_wd    = '0;
        state_next = S_INS_PAR;
      end
      S_INS_PAR: begin
        rd_addr    = parent;
        prev_we    = 1'b1;
        prev_wa    = node;
        prev_wd    = parent;
        state_next = S_INS_LINK;
      end
      S_INS_LINK: begin
        next_we    = 1'b1;
        next_wa    = node;
        next_wd    = par_next;
        state_next = S_INS_TAIL;
      end
      S_INS_TAIL: begin
        next_we    = 1'b1;
        next_wa    = parent;
        next_wd    = node;
        prev_we    = (nlink != '0);
        prev_wa    = nlink;
        prev_wd    = node;
        val_we     = 1'b1;
        state_next = S_OUT;
      end
      S_DRP_UNLINK: begin
        next_we    = 1'b1;
        next_wa    = prev_rd;
        next_wd    = next_rd;
        prev_we    = (next_rd != '0);
        prev_wa    = next_rd;
        prev_wd    = prev_rd;
        state_next = S_DRP_PUSH;
      end
      S_DRP_PUSH: begin
        next_we    = 1'b1;
        next_wa    = node;
        next_wd    = free_head;
        prev_we    = (free_head != '0);
        prev_wa    = free_head;
        prev_wd    = node;
        state_next = S_DRP_FREE;
      end
      S_DRP_FREE: begin
        prev_we    = 1'b1;
        prev_wa    = node;
        prev_wd    = '0;
        state_next = S_OUT;
      end
      S_VER_LIVE: begin
        rd_addr    = root_next;
        state_next = (root_next == '0) ? S_VER_FREE : S_VER_STEP;
      end
      S_VER_FREE: begin
        rd_addr    = free_head;
        state_next = (free_head == '0) ? S_VER_END : S_VER_STEP;
      end
      S_VER_STEP: begin
        // follow the link straight out of the read register
        rd_addr = next_rd;
        if (steps >= DEPTH_CNT || next_rd == '0) begin
          state_next = walk_free ? S_VER_END : S_VER_FREE;
        end
      end
      S_VER_END: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // node memories: entry 0 of the next links lives in root_next
  always_ff @(posedge clk) begin
    if (next_we && next_wa != '0) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (val_we) begin
      val_mem[node] <= value;
    end
    next_rd <= next_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_next <= '0;
    end else if (next_we && next_wa == '0) begin
      root_next <= next_wd;
    end
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      used_count <= CNT_W'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && in_op == OP_INSERT && free_head == '0 && used_count < DEPTH_CNT) begin
            used_count <= used_count + CNT_W'(1);
          end
        end
        S_INS_FREE: free_head <= next_rd;
        S_DRP_FREE: free_head <= node;
        default: ;
      endcase
    end
  end

  // request fields, walk state and pending result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          parent     <= in_parent;
          value      <= in_value;
          res_index  <= '0;
          res_status <= STAT_OK;
          back_bad   <= 1'b0;
          over       <= 1'b0;
          tally      <= TALLY_W'(1);
          walk_free  <= 1'b0;
          case (in_op)
            OP_INSERT: begin
              node <= (free_head != '0) ? free_head : used_count[IDX_W-1:0];
              if (free_head == '0 && used_count >= DEPTH_CNT) begin
                res_status <= STAT_FULL;
              end
            end
            OP_DROP: begin
              node <= in_drop;
              if (in_drop == '0) begin
                res_status <= STAT_BAD_ARG;
              end
            end
            OP_VERIFY: over <= (used_count > DEPTH_CNT);
            default:   res_status <= STAT_BAD_ARG;
          endcase
        end
      end
      S_INS_LINK: nlink <= (parent == node) ? node : par_next;
      S_INS_TAIL: res_index <= node;
      S_VER_LIVE: begin
        cur   <= root_next;
        back  <= '0;
        steps <= '0;
      end
      S_VER_FREE: begin
        walk_free <= 1'b1;
        cur       <= free_head;
        back      <= '0;
        steps     <= '0;
      end
      S_VER_STEP: begin
        if (steps >= DEPTH_CNT) begin
          over <= 1'b1;
        end else begin
          if (prev_rd != back) begin
            back_bad <= 1'b1;
          end
          back  <= cur;
          cur   <= next_rd;
          tally <= tally + TALLY_W'(1);
          steps <= steps + CNT_W'(1);
        end
      end
      S_VER_END: begin
        if (tally != TALLY_W'(used_count)) begin
          over <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_index  <= res_index;
      out_status <= res_status;
      out_back   <= back_bad;
      out_count  <= over;
    end
  end

endmodule

>>> hdl/alm_checker.sv
// Port-level checks for the linked list manager, bound to the top level.
module alm_checker
  import alm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[8:7] != STAT_UNUSED)
    else $error("undefined status code");

  a_index_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] != 7'd0 |-> m_tdata[8:7] == STAT_OK && m_tdata[10:9] == 2'd0)
    else $error("new index on a failed or verify result");

  a_flags_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9] || m_tdata[10]) |-> m_tdata[8:7] == STAT_OK
                                               && m_tdata[6:0] == 7'd0)
    else $error("corruption flags on a non-verify result");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
